[design/bb3_pkg.sv]
// shared types, constants and helper functions of the 3x3 edge-aware box blur
package bb3_pkg;

  localparam int unsigned FW_BITS     = 13;
  localparam int unsigned FH_BITS     = 16;
  localparam int unsigned CFG_DW      = 16;
  localparam int unsigned PIX_BITS    = 24;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } bb3_cfg_idx_t;

  // which neighbours of one output lie inside the frame, plus the frame end mark
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } bb3_nbr_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                drain;
    logic                single_row;
    logic                emit_a;
    logic                emit_b;
    bb3_nbr_t            nbr_a;
    bb3_nbr_t            nbr_b;
    logic [PIX_BITS-1:0] pix;
  } bb3_cmd_t;

  // floor(2^16 / (2*cnt)) for the neighbour counts that can occur
  function automatic logic [15:0] div_magic(input logic [3:0] cnt);
    logic [15:0] m;
    unique case (cnt)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10922;
      4'd4:    m = 16'd8192;
      4'd6:    m = 16'd5461;
      4'd9:    m = 16'd3640;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

endpackage

[design/bb3_queue.sv]
// short command queue between the front and the back
module bb3_queue #(
  parameter int unsigned DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] head_data
);

  localparam int unsigned DEPTH = bb3_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic [DW-1:0] entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full      = (count_r == NW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

[design/bb3_front.sv]
// front: config registers, frame position counters and item classification
module bb3_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [bb3_pkg::CFG_DW-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic                                q_full,
  output logic                                q_push,
  output bb3_pkg::bb3_cmd_t                   q_cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]        q_col
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WEW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WEW > bb3_pkg::FW_BITS) ? WEW : bb3_pkg::FW_BITS;
  localparam int unsigned FHB  = bb3_pkg::FH_BITS;

  logic [bb3_pkg::FW_BITS-1:0] frame_width_r, frame_width_nxt;
  logic [FHB-1:0]              frame_height_r, frame_height_nxt;
  logic [CW-1:0]               in_col_r, in_col_nxt;
  logic [FHB-1:0]              in_row_r, in_row_nxt;
  logic [CW-1:0]               drain_col_r, drain_col_nxt;

  logic [CMPW-1:0] fw_ext, w_eff;
  logic [CW-1:0]   w_last;
  logic [FHB-1:0]  h_eff;
  logic            single_row, row_ok, col_end, accept;
  logic            pix_ok, drain_ok, emit_rows, drain_last;

  always_comb begin
    fw_ext = CMPW'(frame_width_r);
    if (fw_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
  end

  assign w_last     = CW'(w_eff - CMPW'(1));
  assign h_eff      = (frame_height_r == '0) ? FHB'(1) : frame_height_r;
  assign single_row = (h_eff == FHB'(1));
  assign row_ok     = (in_row_r < h_eff);
  assign col_end    = (in_col_r == w_last);
  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign pix_ok     = !in_kind && row_ok;
  assign drain_ok   = in_kind && !row_ok;
  assign emit_rows  = single_row || (in_row_r != '0);
  assign drain_last = (drain_col_r == w_last);
  assign q_push     = accept && (pix_ok || drain_ok);
  assign q_col      = in_kind ? drain_col_r : in_col_r;

  always_comb begin
    q_cmd            = '0;
    q_cmd.drain      = in_kind;
    q_cmd.pix        = {in_red, in_green, in_blue};
    if (in_kind) begin
      q_cmd.emit_a      = 1'b1;
      q_cmd.nbr_a.top   = 1'b1;
      q_cmd.nbr_a.left  = (drain_col_r != '0);
      q_cmd.nbr_a.right = !drain_last;
      q_cmd.nbr_a.last  = drain_last;
    end else begin
      q_cmd.single_row  = single_row;
      q_cmd.emit_a      = emit_rows && (in_col_r != '0);
      q_cmd.emit_b      = emit_rows && col_end;
      q_cmd.nbr_a.top   = !single_row && (in_row_r > FHB'(1));
      q_cmd.nbr_a.bot   = !single_row;
      q_cmd.nbr_a.left  = (in_col_r > CW'(1));
      q_cmd.nbr_a.right = 1'b1;
      q_cmd.nbr_b.top   = q_cmd.nbr_a.top;
      q_cmd.nbr_b.bot   = !single_row;
      q_cmd.nbr_b.left  = (in_col_r != '0);
      q_cmd.nbr_b.last  = single_row;
    end
  end

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    in_col_nxt       = in_col_r;
    in_row_nxt       = in_row_r;
    drain_col_nxt    = drain_col_r;
    if (cfg_wr_en) begin
      unique case (bb3_pkg::bb3_cfg_idx_t'(cfg_index))
        bb3_pkg::CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[bb3_pkg::FW_BITS-1:0];
        bb3_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FHB-1:0];
      endcase
      in_col_nxt    = '0;
      in_row_nxt    = '0;
      drain_col_nxt = '0;
    end else if (accept && pix_ok) begin
      if (col_end) begin
        in_col_nxt = '0;
        in_row_nxt = single_row ? '0 : in_row_r + FHB'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end else if (accept && drain_ok) begin
      if (drain_last) begin
        in_row_nxt    = '0;
        drain_col_nxt = '0;
      end else begin
        drain_col_nxt = drain_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FRAME_WIDTH_RST;
      frame_height_r <= bb3_pkg::FRAME_HEIGHT_RST;
      in_col_r       <= '0;
      in_row_r       <= '0;
      drain_col_r    <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      drain_col_r    <= drain_col_nxt;
    end
  end

endmodule

[design/bb3_back.sv]
// back: line buffers, 3x3 window, neighbourhood sums and rounded division
module bb3_back #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  bb3_pkg::bb3_cmd_t            q_cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_frame_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PB = bb3_pkg::PIX_BITS;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_PRD  = 8'b00000010,
    ST_DRA  = 8'b00000100,
    ST_DRB  = 8'b00001000,
    ST_DRC  = 8'b00010000,
    ST_SUM  = 8'b00100000,
    ST_DIV  = 8'b01000000,
    ST_FIX  = 8'b10000000
  } bb3_state_t;

  typedef struct packed {
    logic [PB-1:0] p0;
    logic [PB-1:0] p1;
    logic [PB-1:0] p2;
  } bb3_col_t;

  bb3_state_t state_r, state_nxt;
  logic       sel_b_r, sel_b_nxt;
  logic       out_valid_r, out_valid_nxt;

  bb3_pkg::bb3_cmd_t cmd_r;
  logic [CW-1:0]     cmd_col_r;

  logic [PB-1:0] upper_mem  [MAX_WIDTH];
  logic [PB-1:0] middle_mem [MAX_WIDTH];
  logic [PB-1:0] rd_up_r, rd_mid_r;
  logic [CW-1:0] raddr;
  logic          ram_re, ram_we;

  bb3_col_t col0_r, col1_r, col2_r;

  logic [11:0] sum_r [3];
  logic [11:0] sum_nxt [3];
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r;
  logic [12:0] n_r [3];
  logic [28:0] prod_r [3];
  logic [4:0]  d_r;
  logic [7:0]  q_fix [3];
  logic [7:0]  res_r [3];
  logic        frame_end_r;
  logic        out_free;

  bb3_pkg::bb3_nbr_t nbr;
  bb3_col_t          col_l, col_c, col_r;
  logic [PB-1:0]     nb_pix [9];
  logic              nb_use [9];
  logic [2:0]        row_use, col_use;
  logic [1:0]        rv, cv;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign ram_we   = (state_r == ST_PRD);
  assign ram_re   = q_pop || (state_r == ST_DRA) || (state_r == ST_DRB);

  // read address: one column per cycle, drains sweep left, centre, right
  always_comb begin
    unique case (state_r)
      ST_IDLE: raddr = q_cmd.drain ? q_col - CW'(1) : q_col;
      ST_DRA:  raddr = cmd_col_r;
      ST_DRB:  raddr = cmd_col_r + CW'(1);
      default: raddr = cmd_col_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      upper_mem[cmd_col_r] <= rd_mid_r;
    end
    if (ram_re) begin
      rd_up_r <= upper_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      middle_mem[cmd_col_r] <= cmd_r.pix;
    end
    if (ram_re) begin
      rd_mid_r <= middle_mem[raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_b_nxt     = sel_b_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_cmd.drain ? ST_DRA : ST_PRD;
        end
      end
      ST_PRD: begin
        if (cmd_r.emit_a) begin
          sel_b_nxt = 1'b0;
          state_nxt = ST_SUM;
        end else if (cmd_r.emit_b) begin
          sel_b_nxt = 1'b1;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRA: state_nxt = ST_DRB;
      ST_DRB: state_nxt = ST_DRC;
      ST_DRC: begin
        sel_b_nxt = 1'b0;
        state_nxt = ST_SUM;
      end
      ST_SUM: state_nxt = ST_DIV;
      ST_DIV: state_nxt = ST_FIX;
      ST_FIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!sel_b_r && cmd_r.emit_b) begin
            sel_b_nxt = 1'b1;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_b_r     <= sel_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window columns: pixels shift in from the right, drains load three columns
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r     <= q_cmd;
      cmd_col_r <= q_col;
    end
    unique case (state_r)
      ST_PRD: begin
        col0_r <= col1_r;
        col1_r <= col2_r;
        col2_r <= '{p0: rd_up_r, p1: rd_mid_r, p2: cmd_r.pix};
      end
      ST_DRA:  col0_r <= '{p0: rd_up_r, p1: rd_mid_r, p2: '0};
      ST_DRB:  col1_r <= '{p0: rd_up_r, p1: rd_mid_r, p2: '0};
      ST_DRC:  col2_r <= '{p0: rd_up_r, p1: rd_mid_r, p2: '0};
      default: ;
    endcase
  end

  // neighbourhood selection and masked sums
  always_comb begin
    nbr   = sel_b_r ? cmd_r.nbr_b : cmd_r.nbr_a;
    col_l = sel_b_r ? col1_r : col0_r;
    col_c = sel_b_r ? col2_r : col1_r;
    col_r = col2_r;
    row_use = {nbr.bot, 1'b1, nbr.top};
    col_use = {nbr.right, 1'b1, nbr.left};
    nb_pix[0] = col_l.p0;
    nb_pix[1] = cmd_r.single_row ? col_l.p2 : col_l.p1;
    nb_pix[2] = col_l.p2;
    nb_pix[3] = col_c.p0;
    nb_pix[4] = cmd_r.single_row ? col_c.p2 : col_c.p1;
    nb_pix[5] = col_c.p2;
    nb_pix[6] = col_r.p0;
    nb_pix[7] = cmd_r.single_row ? col_r.p2 : col_r.p1;
    nb_pix[8] = col_r.p2;
    for (int k = 0; k < 9; k++) begin
      nb_use[k] = row_use[k % 3] && col_use[k / 3];
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        if (nb_use[k]) begin
          sum_nxt[ch] = sum_nxt[ch] + 12'(nb_pix[k][(2 - ch) * 8 +: 8]);
        end
      end
    end
    rv      = 2'd1 + 2'(nbr.top) + 2'(nbr.bot);
    cv      = 2'd1 + 2'(nbr.left) + 2'(nbr.right);
    cnt_nxt = 4'(rv) * 4'(cv);
  end

  // correction of the reciprocal estimate, quotient is at most one short
  always_comb begin
    logic [8:0]  q0;
    logic [13:0] rem;
    for (int ch = 0; ch < 3; ch++) begin
      q0        = prod_r[ch][24:16];
      rem       = 14'(n_r[ch]) - 14'(q0) * 14'(d_r);
      q_fix[ch] = 8'(q0 + 9'(rem >= 14'(d_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= nbr.last;
    end
    if (state_r == ST_DIV) begin
      for (int ch = 0; ch < 3; ch++) begin
        n_r[ch]    <= {sum_r[ch], 1'b0} + 13'(cnt_r);
        prod_r[ch] <= 29'({sum_r[ch], 1'b0} + 13'(cnt_r)) * 29'(bb3_pkg::div_magic(cnt_r));
      end
      d_r <= {cnt_r, 1'b0};
    end
    if ((state_r == ST_FIX) && out_free) begin
      res_r       <= q_fix;
      frame_end_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = res_r[0];
  assign out_green     = res_r[1];
  assign out_blue      = res_r[2];
  assign out_frame_end = frame_end_r;

`ifndef NO_ASSERTIONS
  a_second_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) && sel_b_r |-> cmd_r.emit_b)
    else $error("second output computed for an item that has none");
  a_drain_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) && cmd_r.drain |-> !sel_b_r && !cmd_r.emit_b)
    else $error("drain item producing two outputs");
`endif

endmodule

[design/box_blur_3x3_edge_aware_top.sv]
// top level of the 3x3 edge-aware box blur with line buffers
// usage:
//   input beats carry one pixel (in_kind 0) or one drain request (in_kind 1) in raster
//   order; a result beat carries the rounded 3x3 mean of r, g, b, with out_frame_end on
//   the last pixel of the frame. after the last pixel of a frame, one drain beat per
//   column flushes the final row; a single-row frame needs no drain beats
//   frame_width and frame_height are written through cfg_wr_en / cfg_index / cfg_data
//   while the block is idle; each write restarts the frame
// processing:
//   a beat is taken into a four-entry command queue; the back then works on one
//   command at a time: it reads and then updates the line buffers, and each result
//   takes a sum, a reciprocal multiply and a correction step, so a pixel gives zero,
//   one or two results and a drain beat makes three line buffer column reads then
//   one result
// reset: counters restart, the size goes back to 640 x 480, no result is pending;
//   line buffer contents are not cleared and need no clearing pass
// stall: a held result stays on the output register; the back waits, the queue fills
//   and then in_stall rises
module box_blur_3x3_edge_aware_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [bb3_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_frame_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = $bits(bb3_pkg::bb3_cmd_t) + CW;

  // front to queue
  logic              q_push, q_full;
  bb3_pkg::bb3_cmd_t f_cmd;
  logic [CW-1:0]     f_col;

  // queue to back
  logic              q_pop, q_empty;
  logic [QW-1:0]     q_head;
  bb3_pkg::bb3_cmd_t b_cmd;
  logic [CW-1:0]     b_col;

  assign b_cmd = bb3_pkg::bb3_cmd_t'(q_head[QW-1:CW]);
  assign b_col = q_head[CW-1:0];

  // classification and frame counters
  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd),
    .q_col     (f_col)
  );

  // decouples the front from the back
  bb3_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_cmd, f_col}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_data (q_head)
  );

  // line buffers, window and arithmetic
  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_cmd         (b_cmd),
    .q_col         (b_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule

[verif/box_blur_3x3_edge_aware_top_test.sv]
// self-checking testbench of the 3x3 edge-aware box blur top level
module box_blur_3x3_edge_aware_top_test;

  localparam int LINE_MAX = 4096;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit       drain;
    bit [7:0] r, g, b;
  } beat_t;

  typedef struct {
    bit [7:0] r, g, b;
    bit       fe;
  } blur_px_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic                        cfg_index = bb3_pkg::CFG_FRAME_WIDTH;
  logic [bb3_pkg::CFG_DW-1:0]  cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_kind = 1'b0;
  logic [7:0]                  in_red = '0, in_green = '0, in_blue = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  out_red, out_green, out_blue;
  logic                        out_frame_end;

  box_blur_3x3_edge_aware_top uut (.*);

  always #6 clk = ~clk;

  // mirror of the block: line stores, window and frame counters
  bit [23:0] upper_mem [LINE_MAX];
  bit [23:0] middle_mem [LINE_MAX];
  bit [23:0] win [9];
  int        fw_reg = 640, fh_reg = 480;
  int        in_row, in_col, out_row, out_col;

  beat_t     pending_beats[$];
  blur_px_t  expected_pixels[$];

  int  idle_mode;         // 0 none, 1 sender, 2 receiver, 3 both
  bit  hold_req;          // ask the receiver for one long hold-off
  int  hold_left;
  bit  taken;             // current beat went in at the last rising edge
  int  quiet_cycles;
  int  n_errors, n_results, n_beats, n_frame_ends;

  function automatic int eff_w();
    if (fw_reg == 0) return 1;
    if (fw_reg > LINE_MAX) return LINE_MAX;
    return fw_reg;
  endfunction

  function automatic int eff_h();
    return (fh_reg == 0) ? 1 : fh_reg;
  endfunction

  function automatic bit [23:0] neighbour(int row, int col, int rbase, int cbase,
                                          bit drain, int h);
    int cs, rs;
    if (col < 0 || col >= LINE_MAX) return '0;
    if (drain) return (row == h - 1) ? middle_mem[col] : upper_mem[col];
    cs = col - cbase;
    rs = row - rbase;
    if (cs < 0 || cs > 2 || rs < 0 || rs > 2) return '0;
    return win[cs * 3 + rs];
  endfunction

  // one rounded mean pixel; returns 1 when it closes the frame
  function automatic bit blur_emit(int orow, int ocol, int rbase, int cbase, bit drain);
    int w, h, sr, sg, sb, cnt;
    bit [23:0] p;
    blur_px_t px;
    w = eff_w(); h = eff_h();
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        if (orow + dy >= 0 && orow + dy < h && ocol + dx >= 0 && ocol + dx < w) begin
          p = neighbour(orow + dy, ocol + dx, rbase, cbase, drain, h);
          sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
          cnt++;
        end
    if (cnt == 0) cnt = 1;
    px.r = 8'((2 * sr + cnt) / (2 * cnt));
    px.g = 8'((2 * sg + cnt) / (2 * cnt));
    px.b = 8'((2 * sb + cnt) / (2 * cnt));
    px.fe = (orow == h - 1 && ocol == w - 1);
    expected_pixels.push_back(px);
    if (px.fe) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      return 1'b1;
    end
    if (ocol + 1 >= w) begin
      out_col = 0; out_row = orow + 1;
    end else begin
      out_col = ocol + 1; out_row = orow;
    end
    return 1'b0;
  endfunction

  function automatic void blur_predict(beat_t bt);
    int w, h, r, c, orow;
    bit done;
    w = eff_w(); h = eff_h();
    if (bt.drain) begin
      // early drain and drain after the frame give nothing
      if (in_row < h || out_row >= h) return;
      void'(blur_emit(out_row, out_col, 0, 0, 1'b1));
      return;
    end
    if (in_row >= h || in_col >= w) return;   // pixel after frame
    r = in_row; c = in_col;
    for (int i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = upper_mem[c];
    win[7] = middle_mem[c];
    win[8] = {bt.r, bt.g, bt.b};
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = {bt.r, bt.g, bt.b};
    if (c + 1 >= w) begin
      in_col = 0; in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
    if (h == 1 || r >= 1) begin
      orow = (h == 1) ? 0 : r - 1;
      done = 1'b0;
      if (c >= 1) done = blur_emit(orow, c - 1, r - 2, c - 2, 1'b0);
      if (!done && c == w - 1) void'(blur_emit(orow, c, r - 2, c - 2, 1'b0));
    end
  endfunction

  // rising edge: take beats into the mirror, check results, watchdog
  always @(posedge clk) begin
    blur_px_t want;
    bit busy;
    bit took;
    busy = cfg_wr_en;
    took = 1'b0;
    if (rst_n && cfg_wr_en) begin
      if (cfg_index == bb3_pkg::CFG_FRAME_WIDTH)
        fw_reg = int'(cfg_data[bb3_pkg::FW_BITS-1:0]);
      else
        fh_reg = int'(cfg_data);
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    if (rst_n && in_valid && !in_stall) begin
      blur_predict('{in_kind, in_red, in_green, in_blue});
      took = 1'b1;
      n_beats++;
      busy = 1'b1;
    end
    taken <= took;
    if (rst_n && out_valid && !out_stall) begin
      busy = 1'b1;
      n_results++;
      if (out_frame_end) n_frame_ends++;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected result beat r=%0d g=%0d b=%0d fe=%0b", $time,
                 out_red, out_green, out_blue, out_frame_end);
        n_errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (want.r !== out_red)
          $display("%0t red: expected %0d actual %0d", $time, want.r, out_red);
        if (want.g !== out_green)
          $display("%0t green: expected %0d actual %0d", $time, want.g, out_green);
        if (want.b !== out_blue)
          $display("%0t blue: expected %0d actual %0d", $time, want.b, out_blue);
        if (want.fe !== out_frame_end)
          $display("%0t frame_end: expected %0b actual %0b", $time, want.fe,
                   out_frame_end);
        if (want.r !== out_red || want.g !== out_green || want.b !== out_blue ||
            want.fe !== out_frame_end)
          n_errors++;
      end
    end
    quiet_cycles = busy ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("box_blur_3x3_edge_aware_top_test: errors");
      $finish;
    end
  end

  // sender: new beat at the falling edge once the last one went in
  always @(negedge clk) begin
    beat_t bt;
    bit idle;
    idle = (idle_mode == 1) ? ($urandom_range(0, 99) < 60) :
           (idle_mode == 3) ? ($urandom_range(0, 99) < 38) : 1'b0;
    if (rst_n && (!in_valid || taken)) begin
      if (pending_beats.size() > 0 && !idle) begin
        bt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_kind <= bt.drain;
        in_red <= bt.r; in_green <= bt.g; in_blue <= bt.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == 2) begin
      out_stall <= ($urandom_range(0, 99) < 60);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(0, 99) < 38);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic beat_t rand_pixel();
    beat_t bt;
    bt.drain = 1'b0;
    bt.r = 8'($urandom); bt.g = 8'($urandom); bt.b = 8'($urandom);
    // now and then full-scale channels to hit the rounding extremes
    case ($urandom_range(0, 7))
      0: begin bt.r = 8'hff; bt.g = 8'hff; bt.b = 8'hff; end
      1: begin bt.r = 8'h00; bt.g = 8'h00; bt.b = 8'h00; end
      default: ;
    endcase
    return bt;
  endfunction

  // one frame of w x h pixels, drains for the last row, optional stray beats
  task automatic add_frame(int w, int h, bit noisy);
    beat_t dr;
    dr = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom)};
    for (int i = 0; i < w * h; i++) begin
      pending_beats.push_back(rand_pixel());
      if (noisy && (i == 0 || $urandom_range(0, 15) == 0))
        pending_beats.push_back(dr);        // early drain, ignored
    end
    if (h > 1) begin
      if (noisy) pending_beats.push_back(rand_pixel());   // pixel after frame
      for (int i = 0; i < w; i++) pending_beats.push_back(dr);
    end
    if (noisy) pending_beats.push_back(dr);   // drain after frame end
  endtask

  task automatic cfg_write(bb3_pkg::bb3_cfg_idx_t idx, logic [bb3_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_size(logic [bb3_pkg::CFG_DW-1:0] w, logic [bb3_pkg::CFG_DW-1:0] h);
    cfg_write(bb3_pkg::CFG_FRAME_WIDTH, w);
    cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // all queued beats in, every result out, then a margin for ignored beats
  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int ph_items;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: degenerate sizes, single row and column, corners, stray beats
    set_size(16'd0, 16'd0);             // both act as one
    add_frame(1, 1, 1'b1);
    add_frame(1, 1, 1'b0);
    wait_drained();
    set_size(16'd3, 16'd1);
    add_frame(3, 1, 1'b1);
    wait_drained();
    set_size(16'd1, 16'd3);
    add_frame(1, 3, 1'b0);
    wait_drained();
    set_size(16'd2, 16'd2);
    add_frame(2, 2, 1'b1);
    wait_drained();
    set_size(16'd3, 16'd3);
    add_frame(3, 3, 1'b0);
    wait_drained();

    // widest: masked value above the line length clamps to it, partial row
    set_size(16'hffff, 16'd1);
    for (int i = 0; i < 150; i++) pending_beats.push_back(rand_pixel());
    wait_drained();
    // tallest: a partial frame, then restarted by the next write
    set_size(16'd1, 16'hffff);
    for (int i = 0; i < 20; i++) pending_beats.push_back(rand_pixel());
    wait_drained();

    // random phases cycling through the idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      int w, h;
      idle_mode = ph % 4;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_size(w[bb3_pkg::CFG_DW-1:0], h[bb3_pkg::CFG_DW-1:0]);
      ph_items = 0;
      if (ph == 4) begin
        @(posedge clk);
        hold_req = 1'b1;      // receiver holds, queue fills, input stalls
      end
      while (ph_items < 100) begin
        add_frame(w, h, ($urandom_range(0, 3) == 0));
        ph_items += w * h;
      end
      if (ph == 4) begin
        @(posedge clk);
        hold_req = 1'b0;
      end
      wait_drained();
    end
    idle_mode = 0;
    wait_drained();

    $display("ran %0d input beats, %0d result beats over %0d frame ends", n_beats,
             n_results, n_frame_ends);
    $display("sizes from 1x1 to the full line, stray drains and pixels, mixed stalls");
    if (n_errors == 0 && expected_pixels.size() == 0) begin
      $display("box_blur_3x3_edge_aware_top_test: clean");
    end else begin
      $display("box_blur_3x3_edge_aware_top_test: errors");
    end
    $finish;
  end

endmodule
